// File: rtl/wbte_pkg.sv
package wbte_pkg;

  localparam logic [2:0] OP_START  = 3'd0;
  localparam logic [2:0] OP_ACK    = 3'd1;
  localparam logic [2:0] OP_DATA   = 3'd2;
  localparam logic [2:0] OP_EXPIRE = 3'd3;
  localparam logic [2:0] OP_ERROR  = 3'd4;

  localparam logic [2:0] ACT_DATA    = 3'd1;
  localparam logic [2:0] ACT_ACK     = 3'd2;
  localparam logic [2:0] ACT_STORE   = 3'd3;
  localparam logic [2:0] ACT_IGNORED = 3'd4;
  localparam logic [2:0] ACT_CLOSED  = 3'd5;

  localparam logic [2:0] REG_DIRECTION = 3'd0;
  localparam logic [2:0] REG_BLOCK     = 3'd1;
  localparam logic [2:0] REG_WINDOW    = 3'd2;
  localparam logic [2:0] REG_FILE      = 3'd3;
  localparam logic [2:0] REG_TIMEOUT   = 3'd4;

  localparam logic [15:0] BLK_MIN   = 16'd8;
  localparam logic [15:0] BLK_MAX   = 16'd65464;
  localparam logic [32:0] POS_MAX   = 33'h1_FFFF_FFFF;
  localparam logic [4:0]  RES_MAX   = 5'd16;
  localparam int          BURST_MAX = 16;
  localparam logic [4:0]  BIW_MAX   = 5'd31;
  localparam logic [3:0]  EXP_MAX   = 4'd15;

  typedef enum logic [2:0] {
    EM_DATA, EM_ACK_FB, EM_ACK_ZERO, EM_IGNORED, EM_STORE, EM_CLOSED
  } emit_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_EXPIRE, S_WIN_INIT, S_WIN_DIV, S_WIN_STEP, S_ACK_DIV,
    S_ACK_EVAL, S_ACK_SUB, S_ACK_OPEN, S_DATA, S_DATA2, S_CHECK, S_FLUSH
  } state_e;

  typedef struct packed {
    logic  latch;
    logic  emit;
    emit_e kind;
    logic  clr_exp;
    logic  expire;
    logic  err;
    logic  win_init;
    logic  div_start;
    logic  win_step;
    logic  ack_mul;
    logic  ack_sub;
    logic  data_take;
    logic  data_ack;
    logic  flush;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       dir;
    logic       open;
    logic       sp_zero;
    logic       div_done;
    logic       seen;
    logic       in_range;
    logic       win_last;
    logic       blk_match;
    logic       la_ne_fb;
    logic       ack_now;
    logic       emit_ok;
  } status_t;

endpackage

// File: rtl/wbte_div.sv
module wbte_div import wbte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] a_i,
  input  logic [15:0] b_i,
  output logic        done_o,
  output logic [32:0] q_o,
  output logic [15:0] r_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] q_q, q_d;
  logic [16:0] r_q, r_d, r_sh;
  logic [15:0] b_q, b_d;
  logic        ge;

  // restoring division, one quotient bit per cycle
  assign r_sh = {r_q[15:0], q_q[32]};
  assign ge   = r_sh >= {1'b0, b_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    q_d    = q_q;
    r_d    = r_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      q_d    = a_i;
      r_d    = 17'd0;
      b_d    = b_i;
    end else if (busy_q) begin
      r_d   = ge ? r_sh - {1'b0, b_q} : r_sh;
      q_d   = {q_q[31:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd32) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign q_o    = q_q;
  assign r_o    = r_q[15:0];

endmodule

// File: rtl/wbte_dp.sv
module wbte_dp import wbte_pkg::*; #(
  parameter int WinW = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            dir_i,
  input  logic [15:0]     bs_i,
  input  logic [WinW-1:0] win_i,
  input  logic [31:0]     fs_i,
  input  logic [3:0]      lim_i,
  input  logic [2:0]      op_i,
  input  logic [15:0]     blk_i,
  input  logic [15:0]     len_i,
  input  cmd_t            cmd_i,
  output status_t         st_o,
  input  logic            m_ready_i,
  output logic            m_valid_o,
  output logic [2:0]      m_act_o,
  output logic [15:0]     m_blk_o,
  output logic [31:0]     m_off_o,
  output logic [15:0]     m_cnt_o,
  output logic            m_last_o
);

  logic [32:0] sp_q, sp_d, wsp_q, wsp_d;
  logic [15:0] la_q, la_d, fb_q, fb_d;
  logic [4:0]  biw_q, biw_d, i_q, i_d, res_q, res_d;
  logic [3:0]  exp_q, exp_d;
  logic        ended_q, ended_d, seen_q, seen_d;
  logic [2:0]  op_q;
  logic [15:0] blk_q, len_q;
  logic [32:0] qt_q, qt_d, prod_q;
  logic [15:0] rm_q, rm_d;

  logic        out_v_q, out_v_d, out_last_q, out_last_d;
  logic [2:0]  out_act_q, out_act_d;
  logic [15:0] out_blk_q, out_blk_d, out_cnt_q, out_cnt_d;
  logic [31:0] out_off_q, out_off_d;
  logic        pend_v_q, pend_v_d;
  logic [2:0]  pend_act_q, pend_act_d;
  logic [15:0] pend_blk_q, pend_blk_d, pend_cnt_q, pend_cnt_d;
  logic [31:0] pend_off_q, pend_off_d;

  logic        div_done;
  logic [32:0] div_q;
  logic [15:0] div_r;

  wbte_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .a_i     (sp_q),
    .b_i     (bs_i),
    .done_o  (div_done),
    .q_o     (div_q),
    .r_o     (div_r)
  );

  // window step arithmetic
  logic [15:0] nblk, size, ls, diff_lo, r_adj;
  logic [33:0] psum;
  logic        sat;
  logic [32:0] delta;
  logic [16:0] r2, diff;
  logic [31:0] fs_rem;
  logic [4:0]  biw_inc;
  logic        short_blk, is_open, out_free;
  logic [2:0]  e_act;
  logic [15:0] e_blk, e_cnt;
  logic [31:0] e_off;
  int          burst;

  assign nblk   = qt_q[15:0] + 16'd1;
  assign fs_rem = fs_i - sp_q[31:0];
  always_comb begin
    size = 16'd0;
    if (sp_q < {1'b0, fs_i}) begin
      size = (fs_rem > {16'd0, bs_i}) ? bs_i : fs_rem[15:0];
    end
  end
  assign psum  = {1'b0, sp_q} + {18'd0, bs_i};
  assign sat   = psum > {1'b0, POS_MAX};
  assign delta = POS_MAX - sp_q;
  assign r2    = {1'b0, rm_q} + {1'b0, delta[15:0]};
  assign r_adj = 16'(r2 - {1'b0, bs_i});
  assign burst = (int'(win_i) > BURST_MAX) ? BURST_MAX : int'(win_i);

  assign ls      = qt_q[15:0];
  assign diff_lo = ls - blk_q;
  assign diff    = {ls < blk_q, diff_lo};

  assign biw_inc   = (biw_q == BIW_MAX) ? BIW_MAX : biw_q + 5'd1;
  assign short_blk = len_q < bs_i;

  always_comb begin
    if (exp_q >= lim_i) is_open = 1'b0;
    else if (!dir_i)    is_open = !(ended_q && la_q == fb_q);
    else                is_open = !ended_q;
  end

  assign out_free = !out_v_q || m_ready_i;

  always_comb begin
    st_o.op        = op_q;
    st_o.dir       = dir_i;
    st_o.open      = is_open;
    st_o.sp_zero   = sp_q == 33'd0;
    st_o.div_done  = div_done;
    st_o.seen      = seen_q;
    if (sp_q == 33'd0 && blk_q == 16'd0) st_o.in_range = 1'b1;
    else if (ls < la_q) st_o.in_range = blk_q > la_q || blk_q <= ls;
    else                st_o.in_range = blk_q > la_q && blk_q <= ls;
    st_o.win_last  = size < bs_i || (int'(i_q) + 1) >= burst;
    st_o.blk_match = blk_q == fb_q + 16'd1;
    st_o.la_ne_fb  = la_q != fb_q;
    st_o.ack_now   = int'(biw_q) == int'(win_i) || short_blk;
    st_o.emit_ok   = !pend_v_q || out_free;
  end

  always_comb begin
    e_act = ACT_CLOSED;
    e_blk = 16'd0;
    e_off = 32'd0;
    e_cnt = 16'd0;
    case (cmd_i.kind)
      EM_DATA: begin
        e_act = ACT_DATA;
        e_blk = nblk;
        e_off = sp_q[31:0];
        e_cnt = size;
      end
      EM_ACK_FB: begin
        e_act = ACT_ACK;
        e_blk = fb_q;
      end
      EM_ACK_ZERO: e_act = ACT_ACK;
      EM_IGNORED: begin
        e_act = ACT_IGNORED;
        e_blk = blk_q;
      end
      EM_STORE: begin
        e_act = ACT_STORE;
        e_blk = blk_q;
        e_cnt = len_q;
      end
      default: e_act = ACT_CLOSED;
    endcase
  end

  always_comb begin
    sp_d = sp_q; wsp_d = wsp_q; la_d = la_q; fb_d = fb_q;
    biw_d = biw_q; i_d = i_q; res_d = res_q; exp_d = exp_q;
    ended_d = ended_q; seen_d = seen_q;
    qt_d = qt_q; rm_d = rm_q;
    out_v_d = out_v_q && !m_ready_i;
    out_act_d = out_act_q; out_blk_d = out_blk_q;
    out_off_d = out_off_q; out_cnt_d = out_cnt_q; out_last_d = out_last_q;
    pend_v_d = pend_v_q; pend_act_d = pend_act_q; pend_blk_d = pend_blk_q;
    pend_off_d = pend_off_q; pend_cnt_d = pend_cnt_q;

    if (cmd_i.latch) res_d = 5'd0;
    if (div_done) begin
      qt_d = div_q;
      rm_d = div_r;
    end
    if (cmd_i.clr_exp) exp_d = 4'd0;
    if (cmd_i.err) exp_d = lim_i;
    if (cmd_i.expire) begin
      ended_d = 1'b0;
      if (exp_q != EXP_MAX) exp_d = exp_q + 4'd1;
      if (!dir_i && sp_q != 33'd0) sp_d = wsp_q;
      if (dir_i && seen_q) biw_d = 5'd0;
    end
    if (cmd_i.win_init) begin
      wsp_d = sp_q;
      i_d   = 5'd0;
    end
    if (cmd_i.win_step) begin
      i_d = i_q + 5'd1;
      if (sat) begin
        sp_d = POS_MAX;
        if (r2 >= {1'b0, bs_i}) begin
          qt_d = qt_q + 33'd1;
          rm_d = r_adj;
        end else begin
          rm_d = r2[15:0];
        end
      end else begin
        sp_d = psum[32:0];
        qt_d = qt_q + 33'd1;
      end
      if (size < bs_i) begin
        fb_d    = nblk;
        ended_d = 1'b1;
      end
    end
    if (cmd_i.ack_sub) begin
      sp_d = (prod_q > sp_q) ? 33'd0 : sp_q - prod_q;
      la_d = blk_q;
    end
    if (cmd_i.data_take) begin
      seen_d = 1'b1;
      biw_d  = biw_inc;
      if (blk_q != fb_q + 16'd1) begin
        if (la_q != fb_q) begin
          biw_d = 5'd0;
          la_d  = fb_q;
        end
      end else begin
        fb_d = blk_q;
      end
    end
    if (cmd_i.data_ack) begin
      if (int'(biw_q) == int'(win_i) || short_blk) begin
        biw_d = 5'd0;
        la_d  = fb_q;
      end
      if (short_blk) ended_d = 1'b1;
    end

    // results go through a one-deep hold so the final one can carry last
    if (cmd_i.emit && res_q < RES_MAX) begin
      res_d = res_q + 5'd1;
      if (pend_v_q) begin
        out_v_d    = 1'b1;
        out_act_d  = pend_act_q;
        out_blk_d  = pend_blk_q;
        out_off_d  = pend_off_q;
        out_cnt_d  = pend_cnt_q;
        out_last_d = 1'b0;
      end
      pend_v_d   = 1'b1;
      pend_act_d = e_act;
      pend_blk_d = e_blk;
      pend_off_d = e_off;
      pend_cnt_d = e_cnt;
    end
    if (cmd_i.flush && pend_v_q) begin
      out_v_d    = 1'b1;
      out_act_d  = pend_act_q;
      out_blk_d  = pend_blk_q;
      out_off_d  = pend_off_q;
      out_cnt_d  = pend_cnt_q;
      out_last_d = 1'b1;
      pend_v_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q     <= '0;
      wsp_q    <= '0;
      la_q     <= '0;
      fb_q     <= '0;
      biw_q    <= '0;
      i_q      <= '0;
      res_q    <= '0;
      exp_q    <= '0;
      ended_q  <= 1'b0;
      seen_q   <= 1'b0;
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      sp_q     <= sp_d;
      wsp_q    <= wsp_d;
      la_q     <= la_d;
      fb_q     <= fb_d;
      biw_q    <= biw_d;
      i_q      <= i_d;
      res_q    <= res_d;
      exp_q    <= exp_d;
      ended_q  <= ended_d;
      seen_q   <= seen_d;
      out_v_q  <= out_v_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= op_i;
      blk_q <= blk_i;
      len_q <= len_i;
    end
    if (cmd_i.ack_mul) prod_q <= 33'(diff) * 33'(bs_i);
    qt_q       <= qt_d;
    rm_q       <= rm_d;
    out_act_q  <= out_act_d;
    out_blk_q  <= out_blk_d;
    out_off_q  <= out_off_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
    pend_act_q <= pend_act_d;
    pend_blk_q <= pend_blk_d;
    pend_off_q <= pend_off_d;
    pend_cnt_q <= pend_cnt_d;
  end

  assign m_valid_o = out_v_q;
  assign m_act_o   = out_act_q;
  assign m_blk_o   = out_blk_q;
  assign m_off_o   = out_off_q;
  assign m_cnt_o   = out_cnt_q;
  assign m_last_o  = out_last_q;

endmodule

// File: rtl/wbte_ctrl.sv
module wbte_ctrl import wbte_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_valid_i,
  output logic    s_ready_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   ret_flush_q, ret_flush_d;
  logic   hold;

  // states that may emit or flush wait for room in the result registers
  always_comb begin
    case (state_q)
      S_DECODE, S_EXPIRE, S_WIN_STEP, S_ACK_EVAL, S_DATA, S_DATA2, S_CHECK,
      S_FLUSH: hold = !st_i.emit_ok;
      default: hold = 1'b0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    ret_flush_d = ret_flush_q;
    if (!hold) begin
      case (state_q)
        S_IDLE: if (s_valid_i) state_d = S_DECODE;
        S_DECODE: begin
          if (st_i.op > OP_ERROR) state_d = S_IDLE;
          else if (!st_i.open) state_d = S_FLUSH;
          else begin
            case (st_i.op)
              OP_START: begin
                ret_flush_d = 1'b0;
                state_d = st_i.dir ? S_CHECK : S_WIN_INIT;
              end
              OP_ACK:    state_d = st_i.dir ? S_CHECK : S_ACK_DIV;
              OP_DATA:   state_d = st_i.dir ? S_DATA : S_CHECK;
              OP_EXPIRE: state_d = S_EXPIRE;
              default:   state_d = S_CHECK;
            endcase
          end
        end
        S_EXPIRE: begin
          ret_flush_d = 1'b1;
          state_d = (!st_i.dir && !st_i.sp_zero) ? S_WIN_INIT : S_FLUSH;
        end
        S_WIN_INIT: state_d = S_WIN_DIV;
        S_WIN_DIV:  if (st_i.div_done) state_d = S_WIN_STEP;
        S_WIN_STEP: if (st_i.win_last) state_d = ret_flush_q ? S_FLUSH : S_CHECK;
        S_ACK_DIV:  if (st_i.div_done) state_d = S_ACK_EVAL;
        S_ACK_EVAL: state_d = st_i.in_range ? S_ACK_SUB : S_CHECK;
        S_ACK_SUB:  state_d = S_ACK_OPEN;
        S_ACK_OPEN: begin
          ret_flush_d = 1'b0;
          state_d = st_i.open ? S_WIN_INIT : S_CHECK;
        end
        S_DATA:  state_d = st_i.blk_match ? S_DATA2 : S_CHECK;
        S_DATA2: state_d = S_CHECK;
        S_CHECK: state_d = S_FLUSH;
        S_FLUSH: state_d = S_IDLE;
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = EM_CLOSED;
    s_ready_o  = state_q == S_IDLE;
    if (!hold) begin
      case (state_q)
        S_IDLE: cmd_o.latch = s_valid_i;
        S_DECODE: begin
          if (st_i.op <= OP_ERROR) begin
            if (!st_i.open) begin
              cmd_o.emit = 1'b1;
            end else if (st_i.op != OP_EXPIRE) begin
              cmd_o.clr_exp = 1'b1;
              if (st_i.op == OP_START && st_i.dir) begin
                cmd_o.emit = 1'b1;
                cmd_o.kind = EM_ACK_ZERO;
              end
              if (st_i.op == OP_ACK && !st_i.dir) cmd_o.div_start = 1'b1;
              if (st_i.op == OP_ERROR) cmd_o.err = 1'b1;
            end
          end
        end
        S_EXPIRE: begin
          cmd_o.expire = 1'b1;
          if (st_i.dir && st_i.seen) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = EM_ACK_FB;
          end
        end
        S_WIN_INIT: begin
          cmd_o.win_init  = 1'b1;
          cmd_o.div_start = 1'b1;
        end
        S_WIN_STEP: begin
          cmd_o.win_step = 1'b1;
          cmd_o.emit     = 1'b1;
          cmd_o.kind     = EM_DATA;
        end
        S_ACK_EVAL: begin
          if (st_i.in_range) cmd_o.ack_mul = 1'b1;
          else begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = EM_IGNORED;
          end
        end
        S_ACK_SUB: cmd_o.ack_sub = 1'b1;
        S_DATA: begin
          cmd_o.data_take = 1'b1;
          if (st_i.blk_match) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = EM_STORE;
          end else if (st_i.la_ne_fb) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = EM_ACK_FB;
          end
        end
        S_DATA2: begin
          cmd_o.data_ack = 1'b1;
          if (st_i.ack_now) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = EM_ACK_FB;
          end
        end
        S_CHECK: cmd_o.emit = !st_i.open;
        S_FLUSH: cmd_o.flush = 1'b1;
        default: cmd_o.flush = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_flush_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_flush_q <= ret_flush_d;
    end
  end

endmodule

// File: rtl/windowed_block_transfer_engine_core.sv
// Each request is decoded, handled and its results flushed in turn. A window
// send initializes the window, divides for the first block number and then
// emits one descriptor per step (up to 16); an in-range ack first does its own
// block-number divide. Requests are taken one at a time: a new one is accepted
// only once the engine is back in idle, and result stalls can hold it.
// Reset (async, active low) clears connection state and loads register defaults.
module windowed_block_transfer_engine_core import wbte_pkg::*; #(
  parameter int MAX_WINDOW = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // block_number[15:0], payload_length[31:16]
  input  logic [2:0]  s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // out_block[15:0], byte_offset[47:16],
                                     // byte_count[63:48]
  output logic [2:0]  m_axis_tuser,  // action
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WinW = $clog2(MAX_WINDOW + 1);

  logic        dir_q;
  logic [15:0] bs_q;
  logic [4:0]  win_q;
  logic [31:0] fs_q;
  logic [3:0]  lim_q;
  logic        wr;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
      bs_q  <= 16'd512;
      win_q <= 5'd1;
      fs_q  <= 32'd0;
      lim_q <= 4'd3;
    end else if (wr) begin
      case (idx)
        REG_DIRECTION: dir_q <= pwdata[0];
        REG_BLOCK:     bs_q  <= pwdata[15:0];
        REG_WINDOW:    win_q <= pwdata[4:0];
        REG_FILE:      fs_q  <= pwdata;
        REG_TIMEOUT:   lim_q <= pwdata[3:0];
        default:       dir_q <= dir_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DIRECTION: prdata = {31'd0, dir_q};
      REG_BLOCK:     prdata = {16'd0, bs_q};
      REG_WINDOW:    prdata = {27'd0, win_q};
      REG_FILE:      prdata = fs_q;
      REG_TIMEOUT:   prdata = {28'd0, lim_q};
      default:       prdata = 32'd0;
    endcase
  end

  logic [15:0]     bs_eff;
  logic [WinW-1:0] win_eff;

  assign bs_eff = (bs_q < BLK_MIN) ? BLK_MIN : (bs_q > BLK_MAX) ? BLK_MAX : bs_q;

  always_comb begin
    if (win_q == 5'd0)                win_eff = WinW'(1);
    else if (int'(win_q) > MAX_WINDOW) win_eff = WinW'(MAX_WINDOW);
    else                              win_eff = WinW'(win_q);
  end

  cmd_t    cmd;
  status_t st;

  wbte_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  wbte_dp #(.WinW(WinW)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .dir_i     (dir_q),
    .bs_i      (bs_eff),
    .win_i     (win_eff),
    .fs_i      (fs_q),
    .lim_i     (lim_q),
    .op_i      (s_axis_tuser),
    .blk_i     (s_axis_tdata[15:0]),
    .len_i     (s_axis_tdata[31:16]),
    .cmd_i     (cmd),
    .st_o      (st),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_act_o   (m_axis_tuser),
    .m_blk_o   (m_axis_tdata[15:0]),
    .m_off_o   (m_axis_tdata[47:16]),
    .m_cnt_o   (m_axis_tdata[63:48]),
    .m_last_o  (m_axis_tlast)
  );

endmodule

// File: tb/windowed_block_transfer_engine_core_tb.sv
module windowed_block_transfer_engine_core_tb;
  import wbte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] blk;
    logic [31:0] offset;
    logic [15:0] count;
    logic        last;
  } xfer_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  windowed_block_transfer_engine_core dut (.*);

  // local copy of the engine's registers and connection state
  logic        cfg_dir;
  logic [15:0] cfg_bsize;
  logic [4:0]  cfg_win;
  logic [31:0] cfg_fsize;
  logic [3:0]  cfg_tlimit;
  logic [32:0] m_send_pos, m_win_start;
  logic [15:0] m_last_acked, m_final_blk;
  logic [4:0]  m_biw;
  logic [3:0]  m_expiry;
  logic        m_ended, m_seen;

  xfer_result_t pending_results[$];
  xfer_result_t step_out[$];
  int errors, requests_sent, results_seen, idle_cycles;
  bit recv_stall_on;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    errors++;
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, exp,
             results_seen);
  endtask

  // ---------------- predictor ----------------
  function automatic logic [32:0] eff_bsize();
    if (cfg_bsize < BLK_MIN) return 33'(BLK_MIN);
    if (cfg_bsize > BLK_MAX) return 33'(BLK_MAX);
    return 33'(cfg_bsize);
  endfunction

  function automatic int eff_window();
    int w;
    w = cfg_win;
    if (w < 1) w = 1;
    if (w > 16) w = 16;
    return w;
  endfunction

  function automatic bit conn_open();
    if (m_expiry >= cfg_tlimit) return 0;
    if (!cfg_dir) return !(m_ended && m_last_acked == m_final_blk);
    return !m_ended;
  endfunction

  function automatic void push_result(input logic [2:0] a, input logic [15:0] b,
                                      input logic [31:0] o, input logic [15:0] c);
    xfer_result_t r;
    if (step_out.size() >= 16) return;
    r.action = a; r.blk = b; r.offset = o; r.count = c; r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void send_burst();
    logic [32:0] bs, pos, sz;
    logic [15:0] blk;
    int w;
    bs = eff_bsize();
    w = eff_window();
    m_win_start = m_send_pos;
    for (int i = 0; i < w; i++) begin
      pos = m_send_pos;
      blk = 16'(pos / bs + 1);
      sz = 0;
      if (pos < 33'(cfg_fsize)) begin
        sz = 33'(cfg_fsize) - pos;
        if (sz > bs) sz = bs;
      end
      m_send_pos = ({1'b0, pos} + bs > {1'b0, POS_MAX}) ? POS_MAX : pos + bs;
      push_result(ACT_DATA, blk, pos[31:0], sz[15:0]);
      if (sz < bs) begin
        m_final_blk = blk;
        m_ended = 1'b1;
        break;
      end
    end
  endfunction

  function automatic bit ack_ok(input logic [15:0] a);
    logic [15:0] ls;
    if (m_send_pos == 0 && a == 0) return 1;
    ls = 16'(m_send_pos / eff_bsize());
    if (ls < m_last_acked) return a > m_last_acked || a <= ls;
    return a > m_last_acked && a <= ls;
  endfunction

  function automatic void rewind_send(input logic [15:0] a);
    logic [32:0] bs;
    logic [15:0] lb;
    logic [63:0] diff, d;
    bs = eff_bsize();
    lb = 16'(m_send_pos / bs);
    if (lb == a) return;
    diff = (lb > a) ? 64'(lb - a) : 64'(lb) + 1 + 64'(16'hFFFF - a);
    d = diff * 64'(bs);
    m_send_pos = (d > 64'(m_send_pos)) ? 33'd0 : m_send_pos - 33'(d);
  endfunction

  function automatic void receive_block(input logic [15:0] blk, input logic [15:0] len);
    bit short_blk;
    m_seen = 1'b1;
    if (m_biw < BIW_MAX) m_biw++;
    if (blk != 16'(m_final_blk + 1)) begin
      if (m_last_acked != m_final_blk) begin
        push_result(ACT_ACK, m_final_blk, 0, 0);
        m_biw = 0;
        m_last_acked = m_final_blk;
      end
      return;
    end
    push_result(ACT_STORE, blk, 0, len);
    m_final_blk = blk;
    short_blk = 33'(len) < eff_bsize();
    if (int'(m_biw) == eff_window() || short_blk) begin
      push_result(ACT_ACK, blk, 0, 0);
      m_biw = 0;
      m_last_acked = blk;
    end
    if (short_blk) m_ended = 1'b1;
  endfunction

  function automatic void predict_event(input logic [2:0] op, input logic [15:0] blk,
                                        input logic [15:0] len);
    xfer_result_t r;
    step_out.delete();
    if (op > OP_ERROR) return;
    if (!conn_open()) begin
      push_result(ACT_CLOSED, 0, 0, 0);
    end else if (op == OP_EXPIRE) begin
      m_ended = 1'b0;
      if (m_expiry < EXP_MAX) m_expiry++;
      if (!cfg_dir) begin
        if (m_send_pos != 0) begin
          m_send_pos = m_win_start;
          send_burst();
        end
      end else if (m_seen) begin
        push_result(ACT_ACK, m_final_blk, 0, 0);
        m_biw = 0;
      end
    end else begin
      m_expiry = 0;
      case (op)
        OP_START: begin
          if (!cfg_dir) send_burst();
          else push_result(ACT_ACK, 0, 0, 0);
        end
        OP_ACK: begin
          if (!cfg_dir) begin
            if (!ack_ok(blk)) begin
              push_result(ACT_IGNORED, blk, 0, 0);
            end else begin
              rewind_send(blk);
              m_last_acked = blk;
              if (conn_open()) send_burst();
            end
          end
        end
        OP_DATA: if (cfg_dir) receive_block(blk, len);
        default: m_expiry = cfg_tlimit;
      endcase
      if (!conn_open()) push_result(ACT_CLOSED, 0, 0, 0);
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) begin
      r = step_out[i];
      pending_results.push_back(r);
    end
  endfunction

  // ---------------- drivers ----------------
  task automatic send_event(input logic [2:0] op, input logic [15:0] blk,
                            input logic [15:0] len);
    // gap_len picks the idle gap after the previous request was dropped
    repeat (1 + gap_len()) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {len, blk};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_event(op, blk, len);
    requests_sent++;
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_DIRECTION: cfg_dir    = val[0];
      REG_BLOCK:     cfg_bsize  = val[15:0];
      REG_WINDOW:    cfg_win    = val[4:0];
      REG_FILE:      cfg_fsize  = val;
      REG_TIMEOUT:   cfg_tlimit = val[3:0];
      default: ;
    endcase
  endtask

  task automatic setup(input bit dir, input logic [15:0] bs, input logic [4:0] w,
                       input logic [31:0] fs, input logic [3:0] tl);
    drain();
    write_reg(REG_DIRECTION, 32'(dir));
    write_reg(REG_BLOCK, 32'(bs));
    write_reg(REG_WINDOW, 32'(w));
    write_reg(REG_FILE, fs);
    write_reg(REG_TIMEOUT, 32'(tl));
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk_i) begin
    xfer_result_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(m_axis_tuser), 0);
        end else begin
          e = pending_results.pop_front();
          if (m_axis_tuser !== e.action)
            report_mismatch("action", 32'(m_axis_tuser), 32'(e.action));
          if (m_axis_tdata[15:0] !== e.blk)
            report_mismatch("out_block", 32'(m_axis_tdata[15:0]), 32'(e.blk));
          if (m_axis_tdata[47:16] !== e.offset)
            report_mismatch("byte_offset", m_axis_tdata[47:16], e.offset);
          if (m_axis_tdata[63:48] !== e.count)
            report_mismatch("byte_count", 32'(m_axis_tdata[63:48]), 32'(e.count));
          if (m_axis_tlast !== e.last)
            report_mismatch("last", 32'(m_axis_tlast), 32'(e.last));
        end
      end
      if (recv_stall_on) m_axis_tready <= (gap_len() == 0);
      else m_axis_tready <= 1'b1;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_send_basic();
    setup(1'b0, 16'd512, 5'd4, 32'd3000, 4'd3);
    send_event(OP_START, 0, 0);
    send_event(OP_ACK, 16'd2, 0);
    send_event(OP_ACK, 16'd9, 0);     // outside window
    send_event(OP_DATA, 16'd1, 16'd5); // wrong direction
    send_event(OP_EXPIRE, 0, 0);
    send_event(OP_ACK, 16'd6, 0);
    send_event(OP_START, 0, 0);        // closed
    send_event(3'd5, 16'hFFFF, 16'hFFFF);
    send_event(3'd7, 0, 0);
  endtask

  task automatic test_send_extremes();
    // block size clamped low then high, window clamped, with a huge file
    setup(1'b0, 16'd0, 5'd31, 32'hFFFF_FFFF, 4'd15);
    send_event(OP_START, 0, 0);
    send_event(OP_ACK, 16'd0, 0);
    send_event(OP_ACK, 16'hFFFF, 16'hFFFF);
    setup(1'b0, 16'hFFFF, 5'd16, 32'hFFFF_FFFF, 4'd1);
    send_event(OP_ACK, 16'd0, 0);
    send_event(OP_START, 0, 0);
    send_event(OP_EXPIRE, 0, 0);
    send_event(OP_EXPIRE, 0, 0);
    send_event(OP_ERROR, 0, 0);
  endtask

  task automatic test_receive_basic();
    setup(1'b1, 16'd8, 5'd2, 32'd0, 4'd2);
    send_event(OP_EXPIRE, 0, 0);      // nothing seen yet
    send_event(OP_START, 0, 0);
    send_event(OP_ACK, 16'd1, 0);     // wrong direction
    send_event(OP_DATA, 16'd1, 16'd8);
    send_event(OP_DATA, 16'd2, 16'd8);
    send_event(OP_DATA, 16'd5, 16'd8); // out of order
    send_event(OP_DATA, 16'd3, 16'd8);
    send_event(OP_DATA, 16'd7, 16'd8);
    send_event(OP_EXPIRE, 0, 0);
    send_event(OP_DATA, 16'd4, 16'd0); // short block ends it
    send_event(OP_DATA, 16'd5, 16'd8);
    send_event(OP_ERROR, 0, 0);
  endtask

  task automatic test_random();
    bit dir;
    logic [15:0] bs, blk, len;
    logic [2:0] op;
    int r;
    for (int phase = 0; phase < 18; phase++) begin
      dir = phase[0];
      r = $urandom_range(0, 9);
      bs = (r < 7) ? 16'($urandom_range(8, 64))
                   : (r < 9 ? 16'($urandom) : 16'($urandom_range(0, 7)));
      recv_stall_on = (phase % 4) != 3;
      setup(dir, bs, 5'($urandom_range(0, 31)),
            ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 2000)),
            4'($urandom_range(0, 15)));
      // no reset between phases: error then start does not reopen, so a phase
      // reopens only if its new timeout limit lies above the expiry count
      for (int i = 0; i < 22; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8) op = OP_START;
        else if (r < 50) op = dir ? OP_DATA : OP_ACK;
        else if (r < 62) op = dir ? OP_ACK : OP_DATA;
        else if (r < 80) op = OP_EXPIRE;
        else if (r < 85) op = OP_ERROR;
        else if (r < 88) op = 3'($urandom_range(5, 7));
        else op = dir ? OP_DATA : OP_ACK;
        r = $urandom_range(0, 9);
        if (dir) blk = (r < 7) ? 16'(m_final_blk + 1) : 16'($urandom);
        else blk = (r < 7) ? 16'(m_last_acked + $urandom_range(0, 4)) : 16'($urandom);
        r = $urandom_range(0, 9);
        len = (r < 7) ? cfg_bsize : 16'($urandom);
        send_event(op, blk, len);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cfg_dir = 0; cfg_bsize = 16'd512; cfg_win = 5'd1; cfg_fsize = 0; cfg_tlimit = 4'd3;
    m_send_pos = 0; m_win_start = 0; m_last_acked = 0; m_final_blk = 0;
    m_biw = 0; m_expiry = 0; m_ended = 0; m_seen = 0;
    errors = 0; requests_sent = 0; results_seen = 0; idle_cycles = 0;
    recv_stall_on = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_send_basic();
    test_send_extremes();
    test_receive_basic();
    test_random();
    drain();
    $display("covered %0d events and %0d results over send and receive phases",
             requests_sent, results_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
